FILE: sv/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg
// Shared types and constants of the three-channel interval timer.
// ----------------------------------------------------------------------------
package itc_pkg;

    localparam int CHANNELS_DEF = 3;

    localparam int OP_W     = 2;
    localparam int PORT_W   = 2;
    localparam int DATA_W   = 8;
    localparam int RELOAD_W = 17;
    localparam int DIV_CNT_W = 5;

    localparam logic [RELOAD_W-1:0] RELOAD_FULL = 17'h10000;
    localparam logic [PORT_W-1:0]   PORT_CMD    = 2'd3;
    localparam logic [1:0]          MODE_SQUARE = 2'b11;   // low mode bits of modes 3 and 7

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        AM_LATCH = 2'd0,
        AM_LO    = 2'd1,
        AM_HI    = 2'd2,
        AM_LOHI  = 2'd3
    } t_access;

    typedef enum logic [1:0] {
        BP_LO    = 2'd0,
        BP_HI    = 2'd1,
        BP_LOHI1 = 2'd2,
        BP_LOHI2 = 2'd3
    } t_byte_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_DIV  = 2'b10
    } t_seq_state;

endpackage

FILE: sv/itc_if.sv
// ----------------------------------------------------------------------------
// itc_if
// Request and response channels of the interval timer (valid/ready).
// ----------------------------------------------------------------------------
interface itc_req_if import itc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] data;

    modport source (output valid, output operation, output port, output data, input ready);
    modport sink   (input valid, input operation, input port, input data, output ready);
endinterface

interface itc_rsp_if import itc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              speaker_out;

    modport source (output valid, output read_data, output irq, output speaker_out,
                    input ready);
    modport sink   (input valid, input read_data, input irq, input speaker_out,
                    output ready);
endinterface

FILE: sv/interval_timer_three_channel.sv
// ----------------------------------------------------------------------------
// interval_timer_three_channel
// Up to three interval timer channels behind a byte-wide request port.
// ----------------------------------------------------------------------------
// Each request (byte write, byte read or one count tick) is registered, then
// executed against the channel state once the response register can take its
// result, and the response is registered; one request is taken per cycle while
// the output is not stalled and no tick waits. The exception: if a channel's
// low reload byte is rewritten in lo/hi access while it runs, its phase can
// end up far past the new reload; the next tick then waits on a shared
// bit-serial remainder unit, once per such channel. No clearing pass after reset.
module interval_timer_three_channel import itc_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itc_req_if.sink      i_req,
    itc_rsp_if.source    o_rsp
);

    // request register
    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic [PORT_W-1:0] r_s1_port;
    logic [DATA_W-1:0] r_s1_data;

    // response register
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_rdata;
    logic              r_o_irq;
    logic              r_o_spk;

    // channel state
    logic [RELOAD_W-1:0] r_reload  [CHANNELS];
    logic [RELOAD_W-1:0] r_phase   [CHANNELS];
    t_access             r_access  [CHANNELS];
    logic [2:0]          r_mode    [CHANNELS];
    logic [DATA_W-1:0]   r_latched [CHANNELS];
    t_byte_phase         r_bphase  [CHANNELS];
    logic [CHANNELS-1:0] r_active;
    logic [CHANNELS-1:0] r_level;

    logic [RELOAD_W-1:0] n_reload  [CHANNELS];
    logic [RELOAD_W-1:0] n_phase   [CHANNELS];
    t_access             n_access  [CHANNELS];
    logic [2:0]          n_mode    [CHANNELS];
    logic [DATA_W-1:0]   n_latched [CHANNELS];
    t_byte_phase         n_bphase  [CHANNELS];
    logic [CHANNELS-1:0] n_active;
    logic [CHANNELS-1:0] n_level;

    // reduced phase for channels that need a full remainder on the next tick
    logic [CHANNELS-1:0] r_fix_valid;
    logic [RELOAD_W-1:0] r_fix_val [CHANNELS];

    // remainder unit
    t_seq_state          r_seq;
    logic [CHANNELS-1:0] r_div_sel;
    logic [RELOAD_W-1:0] r_div_num;
    logic [RELOAD_W-1:0] r_div_den;
    logic [RELOAD_W-1:0] r_div_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [RELOAD_W-1:0] eff   [CHANNELS];
    logic [RELOAD_W:0]   p1    [CHANNELS];
    logic [CHANNELS-1:0] need;
    logic [CHANNELS-1:0] pend;
    logic [CHANNELS-1:0] pick;
    logic [RELOAD_W-1:0] pick_num;
    logic [RELOAD_W-1:0] pick_den;
    logic                s1_tick;
    logic                blocked;
    logic                exec;
    logic                div_start;
    logic                div_done;
    logic [RELOAD_W-1:0] div_trial;
    logic [RELOAD_W-1:0] div_next;
    logic [DATA_W-1:0]   rd;
    logic                irq;
    logic                spk;

    // per-channel reload, phase+1 and the "needs full remainder" test
    always_comb begin
        logic found;
        found    = 1'b0;
        pick     = '0;
        pick_num = '0;
        pick_den = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            eff[c]  = (r_reload[c] == '0) ? RELOAD_FULL : r_reload[c];
            p1[c]   = {1'b0, r_phase[c]} + {{RELOAD_W{1'b0}}, 1'b1};
            need[c] = r_active[c] && (p1[c] >= {eff[c], 1'b0});
        end
        pend = need & ~r_fix_valid;
        for (int c = 0; c < CHANNELS; c++) begin
            if (pend[c] && !found) begin
                found    = 1'b1;
                pick[c]  = 1'b1;
                pick_num = p1[c][RELOAD_W-1:0];
                pick_den = eff[c];
            end
        end
    end

    assign s1_tick   = r_s1_valid && (t_op'(r_s1_op) == OP_TICK);
    assign blocked   = (r_seq != SEQ_IDLE) || (s1_tick && (pend != '0));
    assign exec      = r_s1_valid && !blocked && (!r_o_valid || o_rsp.ready);
    assign div_start = (r_seq == SEQ_IDLE) && s1_tick && (pend != '0);
    assign div_done  = (r_seq == SEQ_DIV) && (r_div_cnt == '0);

    assign i_req.ready = !r_s1_valid || exec;

    // restoring remainder step, one numerator bit per cycle
    assign div_trial = {r_div_rem[RELOAD_W-2:0], r_div_num[RELOAD_W-1]};
    assign div_next  = (div_trial >= r_div_den) ? div_trial - r_div_den : div_trial;

    // execute one request against the channel state
    always_comb begin
        logic [RELOAD_W-1:0] nr;
        logic [RELOAD_W-1:0] np;
        logic [RELOAD_W-1:0] cnt;
        logic                start;
        logic                out;
        for (int c = 0; c < CHANNELS; c++) begin
            n_reload[c]  = r_reload[c];
            n_phase[c]   = r_phase[c];
            n_access[c]  = r_access[c];
            n_mode[c]    = r_mode[c];
            n_latched[c] = r_latched[c];
            n_bphase[c]  = r_bphase[c];
        end
        n_active = r_active;
        n_level  = r_level;
        rd       = '0;
        irq      = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            nr    = r_reload[c];
            np    = r_phase[c];
            start = 1'b0;
            out   = 1'b0;
            cnt   = r_reload[c] - r_phase[c];
            if (exec) begin
                case (t_op'(r_s1_op))
                    OP_WRITE: begin
                        if (r_s1_port == PORT_CMD) begin
                            if (int'(r_s1_data[7:6]) == c) begin
                                n_access[c] = t_access'(r_s1_data[5:4]);
                                n_mode[c]   = r_s1_data[3:1];
                                unique case (t_access'(r_s1_data[5:4]))
                                    AM_LATCH: n_latched[c] = cnt[7:0];
                                    AM_LO: begin
                                        n_bphase[c] = BP_LO;
                                        n_active[c] = 1'b0;
                                    end
                                    AM_HI: begin
                                        n_bphase[c] = BP_HI;
                                        n_active[c] = 1'b0;
                                    end
                                    default: begin
                                        n_bphase[c] = BP_LOHI1;
                                        n_active[c] = 1'b0;
                                    end
                                endcase
                            end
                        end else if (int'(r_s1_port) == c) begin
                            unique case (r_bphase[c])
                                BP_LO: begin
                                    nr    = {9'd0, r_s1_data};
                                    start = 1'b1;
                                end
                                BP_HI: begin
                                    nr    = {1'b0, r_s1_data, 8'd0};
                                    start = 1'b1;
                                end
                                BP_LOHI1: begin
                                    nr          = {1'b0, r_reload[c][15:8], r_s1_data};
                                    n_bphase[c] = BP_LOHI2;
                                end
                                default: begin
                                    nr          = {1'b0, r_s1_data, r_reload[c][7:0]};
                                    n_bphase[c] = BP_LOHI1;
                                    start       = 1'b1;
                                end
                            endcase
                            if (start) begin
                                n_active[c] = 1'b1;
                                n_phase[c]  = '0;
                            end
                            n_reload[c] = (nr == '0) ? RELOAD_FULL : nr;
                        end
                    end
                    OP_READ: begin
                        if (int'(r_s1_port) == c) begin
                            case (r_access[c])
                                AM_LATCH: rd = r_latched[c];
                                AM_HI:    rd = cnt[15:8];
                                default:  rd = cnt[7:0];
                            endcase
                        end
                    end
                    OP_TICK: begin
                        if (r_active[c]) begin
                            if (r_fix_valid[c]) begin
                                np = r_fix_val[c];
                            end else if (p1[c] >= {1'b0, eff[c]}) begin
                                np = RELOAD_W'(p1[c] - {1'b0, eff[c]});
                            end else begin
                                np = p1[c][RELOAD_W-1:0];
                            end
                            out = (r_mode[c][1:0] == MODE_SQUARE) &&
                                  ({1'b0, np} < (({1'b0, eff[c]} + 1'b1) >> 1));
                            n_phase[c] = np;
                        end
                        if (c == 0 && !r_level[c] && out) begin
                            irq = 1'b1;
                        end
                        n_level[c] = out;
                    end
                    default: ;
                endcase
            end
        end
        spk = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (c == 2) begin
                spk = n_level[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_seq       <= SEQ_IDLE;
            r_fix_valid <= '0;
            r_active    <= '0;
            r_level     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_reload[c]  <= '0;
                r_phase[c]   <= '0;
                r_access[c]  <= AM_LATCH;
                r_mode[c]    <= '0;
                r_latched[c] <= '0;
                r_bphase[c]  <= BP_LO;
            end
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            r_o_valid <= exec || (r_o_valid && !o_rsp.ready);
            for (int c = 0; c < CHANNELS; c++) begin
                r_reload[c]  <= n_reload[c];
                r_phase[c]   <= n_phase[c];
                r_access[c]  <= n_access[c];
                r_mode[c]    <= n_mode[c];
                r_latched[c] <= n_latched[c];
                r_bphase[c]  <= n_bphase[c];
            end
            r_active <= n_active;
            r_level  <= n_level;

            if (exec) begin
                r_fix_valid <= '0;
            end else if (div_done) begin
                r_fix_valid <= r_fix_valid | r_div_sel;
            end

            unique case (r_seq)
                SEQ_IDLE: begin
                    if (div_start) begin
                        r_seq <= SEQ_DIV;
                    end
                end
                SEQ_DIV: begin
                    if (div_done) begin
                        r_seq <= SEQ_IDLE;
                    end
                end
                default: r_seq <= SEQ_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_op   <= i_req.operation;
            r_s1_port <= i_req.port;
            r_s1_data <= i_req.data;
        end
        if (exec) begin
            r_o_rdata <= rd;
            r_o_irq   <= irq;
            r_o_spk   <= spk;
        end
        if (div_start) begin
            r_div_sel <= pick;
            r_div_num <= pick_num;
            r_div_den <= pick_den;
            r_div_rem <= '0;
            r_div_cnt <= DIV_CNT_W'(RELOAD_W - 1);
        end else if (r_seq == SEQ_DIV) begin
            r_div_num <= {r_div_num[RELOAD_W-2:0], 1'b0};
            r_div_rem <= div_next;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (div_done && r_div_sel[c]) begin
                r_fix_val[c] <= div_next;
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.read_data   = r_o_rdata;
    assign o_rsp.irq         = r_o_irq;
    assign o_rsp.speaker_out = r_o_spk;

endmodule
